>>> design/pair_distance_histogram_macros.svh
// assertion macros shared by the pair distance histogram design
// no dependencies; included by modules that carry concurrent checks
`ifndef PAIR_DISTANCE_HISTOGRAM_MACROS_SVH
`define PAIR_DISTANCE_HISTOGRAM_MACROS_SVH

// same-cycle implication, disabled during reset
`define PDH_ASSERT_NOW(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("pdh check failed");

// next-cycle implication, disabled during reset
`define PDH_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("pdh check failed");

`endif

>>> design/pdh_pkg.sv
// shared types, codes and constants for the pair distance histogram
// no dependencies; used by every module of the block
package pdh_pkg;

  localparam int COORD_BITS    = 24;
  localparam int MAX_ATOMS_DEF = 1024;
  localparam int NBIN_DEF      = 50;
  localparam int CNT_BITS      = 32;
  localparam int PAIR_BITS     = 20;
  localparam int ACNT_BITS     = 11;
  localparam int AIDX_BITS     = 10;
  localparam int BIDX_BITS     = 6;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int THR_IDX_BITS  = 10;
  // squared distance: three squares of a (COORD_BITS+1)-bit magnitude
  localparam int SQ_BITS       = 2 * COORD_BITS + 4;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_PASS  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_X      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Y      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Z      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ATOM_COUNT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIN_WIDTH  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_INIT,
    ST_THRESH,
    ST_PAIRS,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    mode_t                 mode;
    logic [AIDX_BITS-1:0]  atom_index;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] pos_z;
    logic [BIDX_BITS-1:0]  bin_index;
  } in_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]  bin_count;
    logic [PAIR_BITS-1:0] pairs_in_range;
    logic                 saturated;
  } out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } pos_t;

  // one pair travelling down the bin cells
  typedef struct packed {
    logic               valid;
    logic               placed;
    logic               last;
    logic               sat;
    logic [SQ_BITS-1:0] dist2;
  } tok_t;

  // broadcast control to the bin cells
  typedef struct packed {
    logic                    clear;
    logic                    thr_we;
    logic [THR_IDX_BITS-1:0] thr_idx;
  } cell_ctl_t;

endpackage

>>> design/pair_distance_histogram.sv
// top level of the pair distance histogram: control, position store, cell row
// depends on pdh_pkg, pdh_pair_unit, pdh_bin_cell and the macros header
//
//  channel | ports                          | transaction
//  --------+--------------------------------+-----------------------------------
//  input   | start, busy, in_data           | start high while busy low
//  result  | out_valid, out_data            | one-cycle strobe, no back-pressure
//  config  | cfg_valid, cfg_ready, cfg_index,| valid and ready both high
//          | cfg_wdata                      |
//
// load, read and clear are done when accepted; the result strobes the cycle after.
// a pair pass sets up the NBIN bin thresholds, then issues one ordered pair per
// cycle, max(n,1)^2 with n the clamped atom count, then drains the pair pipeline
// and the bin cell row; the result strobes after. busy is high during a pass.
// results cannot be stalled. reset clears the histogram, the saturation flag and
// the atom count, and sets every box size to all ones and the bin width to one.
`include "pair_distance_histogram_macros.svh"

module pair_distance_histogram #(
  parameter int MAX_ATOMS = pdh_pkg::MAX_ATOMS_DEF,
  parameter int NBIN      = pdh_pkg::NBIN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  pdh_pkg::in_t                        in_data,
  output logic                                out_valid,
  output pdh_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pdh_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pdh_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int C        = pdh_pkg::COORD_BITS;
  localparam int AW       = $clog2(MAX_ATOMS);
  localparam int BW       = (NBIN > 1) ? $clog2(NBIN) : 1;
  localparam int THR_BITS = 2 * (C + $clog2(NBIN + 1)) + 2;
  localparam int TI       = pdh_pkg::THR_IDX_BITS;

  pdh_pkg::state_t state_r, state_nxt;

  logic [C-1:0]                   box_r [3];
  logic [pdh_pkg::ACNT_BITS-1:0]  acnt_r;
  logic [C-1:0]                   bw_r;
  logic [2*C-1:0]                 w2_r;
  logic [THR_BITS-1:0]            t_r;
  logic [THR_BITS-1:0]            d_r;
  logic [TI-1:0]                  k_r;
  logic [AW-1:0]                  i_r, j_r, nl_r;
  logic [31:0]                    n_cl;
  logic [AW-1:0]                  nl_nxt;
  pdh_pkg::pos_t                  mem [MAX_ATOMS];
  pdh_pkg::pos_t                  rd_i_r, rd_j_r;
  logic                           tag_valid_r, tag_last_r;
  logic [pdh_pkg::PAIR_BITS-1:0]  pairs_r;
  logic [pdh_pkg::PAIR_BITS-1:0]  pairs_sum;
  logic                           flag_r;
  logic                           out_valid_r;
  pdh_pkg::out_t                  out_r;
  logic                           accept;
  logic                           load_we;
  logic                           issue;
  logic                           thr_we;
  logic                           clr;
  logic                           pair_end;
  logic                           thr_end;
  logic                           ex_done;
  logic [BW-1:0]                  rd_sel;
  logic                           rd_ok;
  pdh_pkg::cell_ctl_t             ctl;
  pdh_pkg::tok_t                  chain [NBIN+1];
  logic [pdh_pkg::CNT_BITS-1:0]   cnt_a [NBIN];

  assign busy      = (state_r != pdh_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign pair_end  = (i_r == nl_r) && (j_r == nl_r);
  assign thr_end   = (k_r == TI'(NBIN - 1));
  assign ex_done   = chain[NBIN].last;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pdh_pkg::ST_IDLE: begin
        if (accept && in_data.mode == pdh_pkg::MODE_PASS) state_nxt = pdh_pkg::ST_SQUARE;
      end
      pdh_pkg::ST_SQUARE: state_nxt = pdh_pkg::ST_INIT;
      pdh_pkg::ST_INIT:   state_nxt = pdh_pkg::ST_THRESH;
      pdh_pkg::ST_THRESH: begin
        if (thr_end) state_nxt = pdh_pkg::ST_PAIRS;
      end
      pdh_pkg::ST_PAIRS: begin
        if (pair_end) state_nxt = pdh_pkg::ST_DRAIN;
      end
      pdh_pkg::ST_DRAIN: begin
        if (ex_done) state_nxt = pdh_pkg::ST_IDLE;
      end
      default: state_nxt = pdh_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    issue   = 1'b0;
    thr_we  = 1'b0;
    unique case (state_r)
      pdh_pkg::ST_THRESH: thr_we = 1'b1;
      pdh_pkg::ST_PAIRS:  issue  = 1'b1;
      default: ;
    endcase
    load_we = accept && in_data.mode == pdh_pkg::MODE_LOAD
              && (int'(in_data.atom_index) < MAX_ATOMS);
    clr     = accept && in_data.mode == pdh_pkg::MODE_CLEAR;
  end

  always_comb begin
    ctl.clear   = clr;
    ctl.thr_we  = thr_we;
    ctl.thr_idx = k_r;
  end

  // clamped atom count and index of the last atom
  always_comb begin
    n_cl   = (int'(acnt_r) > MAX_ATOMS) ? 32'(MAX_ATOMS) : 32'(acnt_r);
    nl_nxt = (n_cl == 32'd0) ? '0 : AW'(n_cl - 32'd1);
  end

  // read selection
  always_comb begin
    rd_sel = BW'(in_data.bin_index);
    rd_ok  = (int'(in_data.bin_index) < NBIN);
  end

  assign pairs_sum = pairs_r + pdh_pkg::PAIR_BITS'(chain[NBIN].valid && chain[NBIN].placed);

  // state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pdh_pkg::ST_IDLE;
      box_r[0] <= '1;
      box_r[1] <= '1;
      box_r[2] <= '1;
      acnt_r   <= '0;
      bw_r     <= C'(1);
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pdh_pkg::REG_BOX_X:      box_r[0] <= C'(cfg_wdata);
          pdh_pkg::REG_BOX_Y:      box_r[1] <= C'(cfg_wdata);
          pdh_pkg::REG_BOX_Z:      box_r[2] <= C'(cfg_wdata);
          pdh_pkg::REG_ATOM_COUNT: acnt_r   <= pdh_pkg::ACNT_BITS'(cfg_wdata);
          pdh_pkg::REG_BIN_WIDTH:  bw_r     <= C'(cfg_wdata);
          default: ;
        endcase
      end
    end
  end

  // bin edge generator: squared upper edges ((k+1)*w)^2 by running sums
  always_ff @(posedge clk) begin
    unique case (state_r)
      pdh_pkg::ST_SQUARE: w2_r <= bw_r * bw_r;
      pdh_pkg::ST_INIT: begin
        t_r <= THR_BITS'(w2_r);
        d_r <= THR_BITS'(w2_r) + (THR_BITS'(w2_r) << 1);
        k_r <= '0;
      end
      pdh_pkg::ST_THRESH: begin
        t_r <= t_r + d_r;
        d_r <= d_r + (THR_BITS'(w2_r) << 1);
        k_r <= k_r + 1'b1;
      end
      default: ;
    endcase
  end

  // pair sequencer
  always_ff @(posedge clk) begin
    if (accept) begin
      i_r  <= '0;
      j_r  <= '0;
      nl_r <= nl_nxt;
    end else if (issue) begin
      if (j_r == nl_r) begin
        j_r <= '0;
        i_r <= i_r + 1'b1;
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
  end

  // position store
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[AW'(in_data.atom_index)] <= '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};
    end
    rd_i_r <= mem[i_r];
    rd_j_r <= mem[j_r];
  end

  // read tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_valid_r <= 1'b0;
      tag_last_r  <= 1'b0;
    end else begin
      tag_valid_r <= issue && (i_r != j_r);
      tag_last_r  <= issue && pair_end;
    end
  end

  pdh_pair_unit u_pair (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (tag_valid_r),
    .in_last  (tag_last_r),
    .pos_i    (rd_i_r),
    .pos_j    (rd_j_r),
    .box_x    (box_r[0]),
    .box_y    (box_r[1]),
    .box_z    (box_r[2]),
    .tok_o    (chain[0])
  );

  // row of bin cells
  for (genvar k = 0; k < NBIN; k++) begin : g_cell
    pdh_bin_cell #(
      .IDX      (k),
      .THR_BITS (THR_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .thr_val (t_r),
      .tok_i   (chain[k]),
      .tok_o   (chain[k+1]),
      .cnt_o   (cnt_a[k])
    );
  end

  // pair count, saturation flag and results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_r     <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (accept && in_data.mode == pdh_pkg::MODE_PASS) begin
        pairs_r <= '0;
      end else begin
        pairs_r <= pairs_sum;
      end
      if (clr) begin
        flag_r <= 1'b0;
      end else if (chain[NBIN].sat) begin
        flag_r <= 1'b1;
      end
      if (accept && in_data.mode != pdh_pkg::MODE_PASS) begin
        out_valid_r <= 1'b1;
      end else if (state_r == pdh_pkg::ST_DRAIN && ex_done) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r.bin_count      <= '0;
      out_r.pairs_in_range <= '0;
      out_r.saturated      <= flag_r;
      case (in_data.mode)
        pdh_pkg::MODE_READ:  out_r.bin_count <= rd_ok ? cnt_a[rd_sel] : '0;
        pdh_pkg::MODE_CLEAR: out_r.saturated <= 1'b0;
        default: ;
      endcase
    end else if (state_r == pdh_pkg::ST_DRAIN && ex_done) begin
      out_r.bin_count      <= '0;
      out_r.pairs_in_range <= pairs_sum;
      out_r.saturated      <= flag_r | chain[NBIN].sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `PDH_ASSERT_NEXT(a_drain_gives_result, clk, rst_n, (state_r == pdh_pkg::ST_DRAIN) && ex_done, out_valid_r)
  `PDH_ASSERT_NOW(a_no_result_mid_pass, clk, rst_n, (state_r == pdh_pkg::ST_THRESH) || (state_r == pdh_pkg::ST_PAIRS), !out_valid_r)
  `PDH_ASSERT_NEXT(a_clear_empties, clk, rst_n, clr, out_valid_r && !out_r.saturated && cnt_a[0] == '0)
  `PDH_ASSERT_NOW(a_self_pair_dropped, clk, rst_n, tag_valid_r, $past(i_r != j_r))

endmodule

>>> design/pdh_pair_unit.sv
// pair unit: minimum-image difference, squares and squared distance
// depends on pdh_pkg
module pdh_pair_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_last,
  input  pdh_pkg::pos_t                   pos_i,
  input  pdh_pkg::pos_t                   pos_j,
  input  logic [pdh_pkg::COORD_BITS-1:0]  box_x,
  input  logic [pdh_pkg::COORD_BITS-1:0]  box_y,
  input  logic [pdh_pkg::COORD_BITS-1:0]  box_z,
  output pdh_pkg::tok_t                   tok_o
);

  localparam int C   = pdh_pkg::COORD_BITS;
  localparam int DW  = C + 2;
  localparam int AW  = C + 1;
  localparam int QW  = 2 * AW;
  localparam int SW  = pdh_pkg::SQ_BITS;

  logic [C-1:0]          pi [3];
  logic [C-1:0]          pj [3];
  logic [C-1:0]          bx [3];
  logic signed [DW:0]    bs [3];
  logic signed [DW-1:0]  diff [3];
  logic signed [DW-1:0]  d1_nxt [3];
  logic signed [DW-1:0]  d1_r [3];
  logic signed [DW-1:0]  d2 [3];
  logic [AW-1:0]         ab_nxt [3];
  logic [AW-1:0]         ab_r [3];
  logic [QW-1:0]         sq_r [3];
  logic [SW-1:0]         sum_r;
  logic [3:0]            vld_r;
  logic [3:0]            lst_r;

  assign pi[0] = pos_i.x;
  assign pi[1] = pos_i.y;
  assign pi[2] = pos_i.z;
  assign pj[0] = pos_j.x;
  assign pj[1] = pos_j.y;
  assign pj[2] = pos_j.z;
  assign bx[0] = box_x;
  assign bx[1] = box_y;
  assign bx[2] = box_z;

  // first wrap: pull down when twice the difference reaches the box
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      bs[a]   = $signed({3'b000, bx[a]});
      diff[a] = $signed({2'b00, pj[a]}) - $signed({2'b00, pi[a]});
      if ($signed({diff[a], 1'b0}) >= bs[a]) begin
        d1_nxt[a] = DW'($signed({diff[a][DW-1], diff[a]}) - bs[a]);
      end else begin
        d1_nxt[a] = diff[a];
      end
    end
  end

  // second wrap and magnitude
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if ($signed({d1_r[a], 1'b0}) < -bs[a]) begin
        d2[a] = DW'($signed({d1_r[a][DW-1], d1_r[a]}) + bs[a]);
      end else begin
        d2[a] = d1_r[a];
      end
      ab_nxt[a] = d2[a][DW-1] ? AW'(-d2[a]) : AW'(d2[a]);
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      d1_r[a] <= d1_nxt[a];
      ab_r[a] <= ab_nxt[a];
      sq_r[a] <= ab_r[a] * ab_r[a];
    end
    sum_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
  end

  // tag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      lst_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_valid};
      lst_r <= {lst_r[2:0], in_last};
    end
  end

  always_comb begin
    tok_o.valid  = vld_r[3];
    tok_o.placed = 1'b0;
    tok_o.last   = lst_r[3];
    tok_o.sat    = 1'b0;
    tok_o.dist2  = sum_r;
  end

endmodule

>>> design/pdh_bin_cell.sv
// one histogram bin cell: threshold, saturating count, token hand-on
// depends on pdh_pkg
module pdh_bin_cell #(
  parameter int IDX      = 0,
  parameter int THR_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pdh_pkg::cell_ctl_t            ctl,
  input  logic [THR_BITS-1:0]           thr_val,
  input  pdh_pkg::tok_t                 tok_i,
  output pdh_pkg::tok_t                 tok_o,
  output logic [pdh_pkg::CNT_BITS-1:0]  cnt_o
);

  localparam logic [pdh_pkg::CNT_BITS-1:0] CNT_MAX = '1;

  logic [THR_BITS-1:0]          thr_r;
  logic [pdh_pkg::CNT_BITS-1:0] cnt_r;
  logic [pdh_pkg::CNT_BITS-1:0] cnt_nxt;
  pdh_pkg::tok_t                tok_r;
  pdh_pkg::tok_t                tok_nxt;
  logic                         hit;
  logic                         full_nxt;

  // pair belongs here when its squared distance is under this bin's upper edge
  always_comb begin
    hit      = tok_i.valid && !tok_i.placed && (THR_BITS'(tok_i.dist2) < thr_r);
    cnt_nxt  = cnt_r;
    full_nxt = 1'b0;
    if (hit && cnt_r != CNT_MAX) begin
      cnt_nxt  = cnt_r + 1'b1;
      full_nxt = (cnt_nxt == CNT_MAX);
    end
    tok_nxt        = tok_i;
    tok_nxt.placed = tok_i.placed | hit;
    tok_nxt.sat    = tok_i.sat | full_nxt;
  end

  // threshold load
  always_ff @(posedge clk) begin
    if (ctl.thr_we && ctl.thr_idx == pdh_pkg::THR_IDX_BITS'(IDX)) begin
      thr_r <= thr_val;
    end
  end

  // count and token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tok_r <= '0;
    end else begin
      cnt_r <= ctl.clear ? '0 : cnt_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;
  assign cnt_o = cnt_r;

endmodule
